// ===== rtl/core/fractional_feedback_delay_top_assert.svh =====
// ----------------------------------------------------------------------------
// fractional_feedback_delay_top_assert.svh
// assertion macros used by the delay line checker
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_FEEDBACK_DELAY_TOP_ASSERT_SVH
`define FRACTIONAL_FEEDBACK_DELAY_TOP_ASSERT_SVH

// assertion on an explicit clock and active-low reset
`define FFD_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the block clock and reset
`define FFD_ASSERT(label, prop, msg) \
  `FFD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/ffd_pkg.sv =====
// ----------------------------------------------------------------------------
// ffd_pkg
// shared types and constants of the fractional feedback delay line
// ----------------------------------------------------------------------------
package ffd_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_WHOLE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_FRACTION = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WET_GAIN       = 4'd3;

  localparam logic [16:0] GAIN_ONE = 17'd32768;

  typedef struct packed {
    logic load;
    logic diff;
    logic interp;
    logic mult;
    logic commit;
  } ffd_cmd_t;

  typedef struct packed {
    logic out_free;
  } ffd_status_t;

endpackage

// ===== rtl/core/ffd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffd_ctrl
// sequencer stepping one sample through read, interpolate, multiply, commit
// ----------------------------------------------------------------------------
module ffd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  ffd_pkg::ffd_status_t status_i,
  output logic                in_stall_o,
  output ffd_pkg::ffd_cmd_t   cmd_o
);
  import ffd_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_INTERP = 3'd2;
  localparam logic [2:0] ST_MULT   = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_INTERP;
      end
      ST_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/ffd_dpath.sv =====
// ----------------------------------------------------------------------------
// ffd_dpath
// delay memory, settings, interpolation, feedback and mix arithmetic
// ----------------------------------------------------------------------------
module ffd_dpath #(
  parameter int unsigned DEPTH       = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [ffd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ffd_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in_i,
  input  logic                                 out_stall_i,
  input  ffd_pkg::ffd_cmd_t                    cmd_i,
  output ffd_pkg::ffd_status_t                 status_o,
  output logic                                 out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]        sample_out_o
);
  import ffd_pkg::*;

  localparam int unsigned SW = SAMPLE_BITS;
  localparam int unsigned AW = $clog2(DEPTH);

  function automatic logic signed [SW-1:0] sat_w(input logic signed [SW+3:0] v);
    logic [4:0] top;
    logic signed [SW-1:0] r;
    top = v[SW+3:SW-1];
    if ((&top) || !(|top)) begin
      r = v[SW-1:0];
    end else if (v[SW+3]) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = {1'b0, {(SW-1){1'b1}}};
    end
    return r;
  endfunction

  // settings
  logic [15:0] dly_whole_q, dly_frac_q, fb_gain_q, wet_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_whole_q <= '0;
      dly_frac_q  <= '0;
      fb_gain_q   <= '0;
      wet_gain_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DELAY_WHOLE:    dly_whole_q <= cfg_data_i;
        REG_DELAY_FRACTION: dly_frac_q  <= cfg_data_i;
        REG_FEEDBACK_GAIN:  fb_gain_q   <= cfg_data_i;
        REG_WET_GAIN:       wet_gain_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // pointer and fill tracking
  logic [AW-1:0] wp_q;
  logic          wrapped_q;
  logic [AW+15:0] whole_ext;
  logic [AW-1:0] offset, tap_idx, old_idx;

  assign whole_ext = {{AW{1'b0}}, dly_whole_q};
  assign offset    = whole_ext[AW-1:0];
  assign tap_idx   = wp_q - offset;
  assign old_idx   = tap_idx - AW'(1);

  // delay memory
  logic signed [SW-1:0] mem [DEPTH];
  logic signed [SW-1:0] tap_rd_q, old_rd_q, wr_data;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem[wp_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tap_rd_q <= mem[tap_idx];
      old_rd_q <= mem[old_idx];
    end
  end

  // pipeline payload
  logic signed [SW-1:0]  x_q, tap_q, delayed_q;
  logic                  tap_ok_q, old_ok_q, zero_whole_q;
  logic signed [SW+17:0] ip_prod_q;
  logic signed [SW+16:0] fb_prod_q, wet_prod_q, dry_prod_q;

  logic signed [SW-1:0]  tap_v, old_v;
  logic signed [SW:0]    diff;
  logic signed [16:0]    frac_s, fb_s, wet_s, dry_s;
  logic signed [SW+17:0] ip_prod, ip_sum;
  logic signed [SW+1:0]  ip_rnd;
  logic signed [SW+16:0] fb_sum;
  logic signed [SW+1:0]  fb_rnd;
  logic signed [SW+17:0] mix_sum;
  logic signed [SW+2:0]  mix_rnd;

  assign tap_v  = zero_whole_q ? x_q : (tap_ok_q ? tap_rd_q : '0);
  assign old_v  = old_ok_q ? old_rd_q : '0;
  assign diff   = (SW+1)'(old_v) - (SW+1)'(tap_v);
  assign frac_s = $signed({1'b0, dly_frac_q});
  assign fb_s   = $signed({1'b0, fb_gain_q});
  assign wet_s  = $signed({1'b0, wet_gain_q});
  assign dry_s  = $signed(GAIN_ONE - {1'b0, wet_gain_q});

  assign ip_prod = (SW+18)'(frac_s) * (SW+18)'(diff);
  assign ip_sum  = ip_prod_q + (SW+18)'(32768);
  assign ip_rnd  = $signed(ip_sum[SW+17:16]);

  assign fb_sum  = fb_prod_q + (SW+17)'(16384);
  assign fb_rnd  = $signed(fb_sum[SW+16:15]);
  assign wr_data = sat_w((SW+4)'(x_q) + (SW+4)'(fb_rnd));

  assign mix_sum = (SW+18)'(wet_prod_q) + (SW+18)'(dry_prod_q) + (SW+18)'(16384);
  assign mix_rnd = $signed(mix_sum[SW+17:15]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q          <= sample_in_i;
      tap_ok_q     <= wrapped_q || (tap_idx < wp_q);
      old_ok_q     <= wrapped_q || (old_idx < wp_q);
      zero_whole_q <= (dly_whole_q == '0);
    end
    if (cmd_i.diff) begin
      tap_q     <= tap_v;
      ip_prod_q <= ip_prod;
    end
    if (cmd_i.interp) begin
      delayed_q <= sat_w((SW+4)'(tap_q) + (SW+4)'(ip_rnd));
    end
    if (cmd_i.mult) begin
      fb_prod_q  <= (SW+17)'(fb_s) * (SW+17)'(delayed_q);
      wet_prod_q <= (SW+17)'(wet_s) * (SW+17)'(delayed_q);
      dry_prod_q <= (SW+17)'(dry_s) * (SW+17)'(x_q);
    end
    if (cmd_i.commit) begin
      sample_out_o <= sat_w((SW+4)'(mix_rnd));
    end
  end

  // control state
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        wp_q <= wp_q + AW'(1);
        if (wp_q == AW'(DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/core/fractional_feedback_delay_top.sv =====
// ----------------------------------------------------------------------------
// fractional_feedback_delay_top
// echo delay line with feedback and linearly interpolated fractional tap
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry one signed sample per item
// output channel: out_valid_o / out_stall_i carry one mixed sample per item
// config channel: cfg_valid_i / cfg_ready_o, cfg_index_i selects delay_whole,
//   delay_fraction, feedback_gain or wet_gain, unknown indexes are dropped;
//   cfg_ready_o is always high, write only while no item is in flight
// the input stalls until the previous item is through, as the sequencer steps
//   through memory read, interpolation multiply, gain multiplies and write-back
// the delay memory has two registered read ports (tap and older sample) and
//   one write port; write-back happens in the last step of each item
// reset: settings and write pointer clear; never-written entries read as
//   zero through a wrap flag, so no clearing pass is needed
// a stalled result holds in the output register; the next item is taken
//   and worked on, and waits at write-back until the output register frees
// DEPTH must be a power of two
// ----------------------------------------------------------------------------
module fractional_feedback_delay_top #(
  parameter int unsigned DEPTH       = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ffd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ffd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]    sample_out_o
);
  import ffd_pkg::*;

  ffd_cmd_t    cmd;
  ffd_status_t status;

  assign cfg_ready_o = 1'b1;

  ffd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  ffd_dpath #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .out_stall_i  (out_stall_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o)
  );

endmodule

// ===== rtl/core/ffd_checker.sv =====
// ----------------------------------------------------------------------------
// ffd_checker
// port-level checks of the delay line handshakes
// ----------------------------------------------------------------------------
`include "fractional_feedback_delay_top_assert.svh"

module ffd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // an item blocks the input for the four steps that follow
  `FFD_ASSERT(a_in_busy, in_valid_i && !in_stall_o |=> in_stall_o [*4], "input taken while busy")

  // a new result appears only out of the write-back step
  `FFD_ASSERT(a_out_from_commit, $rose(out_valid_o) |-> $past(in_stall_o), "stray result")

  `FFD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")

  `FFD_ASSERT(a_out_fall, $fell(out_valid_o) |-> $past(!out_stall_i), "result withdrawn")

endmodule

bind fractional_feedback_delay_top ffd_checker u_ffd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the fractional feedback delay line
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the delay memory, the write pointer
// and the settings. It works out the interpolated tap, the feedback write-back
// and the wet/dry mix for every accepted input item, and checks each accepted
// output item against the oldest expected mix. A short directed run covers
// the sample extremes, zero delay, a fractional-only delay and gains above
// unity. Random phases follow, with new settings written while the block is
// drained, and random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffd_pkg::*;

  localparam int unsigned DEPTH       = 65536;
  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned LIMIT       = 1000000;
  localparam int unsigned LATENCY     = 4;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 236;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  class echo_scoreboard;
    sample_t          echo_mem [DEPTH];
    logic [15:0]      wr_ptr;
    int               whole_dly;
    int               frac_dly;
    int               fb_gain;
    int               wet_mix;
    sample_t          mix_due [$];
    int unsigned      errors;

    function new();
      foreach (echo_mem[i]) echo_mem[i] = '0;
      wr_ptr    = '0;
      whole_dly = 0;
      frac_dly  = 0;
      fb_gain   = 0;
      wet_mix   = 0;
      errors    = 0;
    endfunction

    function longint clamp(longint v);
      longint hi;
      hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DELAY_WHOLE: begin
          whole_dly = data;
        end
        REG_DELAY_FRACTION: begin
          frac_dly = data;
        end
        REG_FEEDBACK_GAIN: begin
          fb_gain = data;
        end
        REG_WET_GAIN: begin
          wet_mix = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void take_sample(sample_t x);
      longint      xs;
      longint      tap;
      longint      older;
      longint      dly;
      longint      fb;
      longint      mix;
      logic [15:0] tap_idx;
      logic [15:0] old_idx;
      xs      = x;
      tap_idx = wr_ptr - 16'(whole_dly);
      old_idx = tap_idx - 16'd1;
      if (whole_dly == 0) tap = xs;
      else tap = echo_mem[tap_idx];
      older = echo_mem[old_idx];
      dly   = tap + ((longint'(frac_dly) * (older - tap) + 32768) >>> 16);
      dly   = clamp(dly);
      fb    = (longint'(fb_gain) * dly + 16384) >>> 15;
      echo_mem[wr_ptr] = sample_t'(clamp(xs + fb));
      mix   = (longint'(wet_mix) * dly + (longint'(32768) - longint'(wet_mix)) * xs
               + 16384) >>> 15;
      mix_due.push_back(sample_t'(clamp(mix)));
      wr_ptr = wr_ptr + 16'd1;
    endfunction

    function void check_mix(sample_t got);
      sample_t want;
      if (mix_due.size() == 0) begin
        $error("sample_out: unexpected item, expected none, actual %0d", got);
        errors++;
      end else begin
        want = mix_due.pop_front();
        if (got !== want) begin
          $error("sample_out: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return mix_due.size();
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  sample_t               sample_in   = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  sample_t               sample_out;

  bit                    calm_in     = 1'b0;
  bit                    calm_out    = 1'b0;
  int unsigned           cycles      = 0;
  echo_scoreboard        sb          = new();

  fractional_feedback_delay_top #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .sample_in_i  (sample_in),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .sample_out_o (sample_out)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.take_sample(sample_in);
      if (out_valid && !out_stall) sb.check_mix(sample_out);
    end
  end

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_t rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return sample_t'($urandom);
    if (r < 75) return sample_t'($signed($urandom_range(0, 2000)) - 1000);
    if (r < 85) return ($urandom_range(0, 1)) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                              : {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    if (r < 92) return {1'b0, {(SAMPLE_BITS-1){1'b1}}} - sample_t'($urandom_range(0, 255));
    return {1'b1, {(SAMPLE_BITS-1){1'b0}}} + sample_t'($urandom_range(0, 255));
  endfunction

  // output stalls, off while calm_out is set
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n = calm_out ? 0 : idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  task automatic send_sample(input sample_t x);
    int gap;
    gap = calm_in ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // lowers the input valid and waits until every item has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_echo(input logic [15:0] whole, input logic [15:0] frac,
                          input logic [15:0] fb, input logic [15:0] wet);
    drain();
    write_reg(REG_DELAY_WHOLE, whole);
    write_reg(REG_DELAY_FRACTION, frac);
    write_reg(REG_FEEDBACK_GAIN, fb);
    write_reg(REG_WET_GAIN, wet);
    write_reg(CFG_IDX_W'($urandom_range(int'(REG_WET_GAIN) + 1, 2**CFG_IDX_W - 1)),
              CFG_DATA_W'($urandom));
  endtask

  function automatic logic [15:0] pick_whole();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 40));
    if (r < 85) return 16'($urandom_range(41, 400));
    if (r < 93) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_gain();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 30) return 16'd32768;
    if (r < 85) return 16'($urandom_range(0, 32768));
    return 16'($urandom);
  endfunction

  initial begin
    sample_t max_s;
    sample_t min_s;
    max_s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    min_s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // settings at reset: zero total delay, dry only
    send_sample(max_s);
    send_sample(min_s);
    send_sample('0);
    send_sample('1);
    send_sample(sample_t'(1));

    // zero whole delay with a fraction, unity feedback, wet only
    set_echo(16'd0, 16'h8000, 16'd32768, 16'd32768);
    send_sample(max_s);
    send_sample(min_s);
    send_sample(sample_t'(12345));
    send_sample(max_s);
    send_sample(min_s);

    // gains just under two, full fraction, saturating
    set_echo(16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (4) send_sample(max_s);
    repeat (4) send_sample(min_s);

    // longest whole delay, no fraction, half mix
    set_echo(16'hFFFF, 16'd0, 16'd0, 16'd16384);
    send_sample(max_s);
    send_sample(min_s);
    send_sample(sample_t'(-7));
    send_sample(sample_t'(7));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_echo(16'd1, 16'hFFFF, 16'd32768, 16'd32768);
        1: set_echo(16'd0, 16'd0, pick_gain(), 16'd0);
        2: set_echo(16'd0, 16'($urandom), pick_gain(), pick_gain());
        default: set_echo(pick_whole(), 16'($urandom), pick_gain(), pick_gain());
      endcase
      calm_in  = (p % 4 == 1);
      calm_out = (p % 4 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == PHASE_ITEMS / 2) drain();
        send_sample(rand_sample());
      end
    end

    calm_in  = 1'b0;
    calm_out = 1'b0;
    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
